FILE: rtl/nots_pkg.sv
// ----------------------------------------------------------------------------
// nots_pkg
// Shared widths, register codes and pipeline types for the nearest occupied
// tile search unit.
// ----------------------------------------------------------------------------
package nots_pkg;

    // request and result field widths
    localparam int CELL_IW   = 12;
    localparam int TILE_VW   = 16;
    localparam int DEPTH_W   = 8;
    localparam int POS_W     = 21;
    localparam int OFF_W     = 22;

    // configuration port
    localparam int CFG_IW    = 3;
    localparam int CFG_DW    = 9;
    localparam int COUNT_W   = 7;
    localparam int SIZE_W    = 9;

    localparam logic [CFG_IW-1:0] REG_WORLD_COLUMNS = 3'd0;
    localparam logic [CFG_IW-1:0] REG_WORLD_ROWS    = 3'd1;
    localparam logic [CFG_IW-1:0] REG_TILE_WIDTH    = 3'd2;
    localparam logic [CFG_IW-1:0] REG_TILE_HEIGHT   = 3'd3;

    // datapath widths
    localparam int CENTER_W  = 19;
    localparam int MAG_W     = 21;
    localparam int SQ_W      = 2 * MAG_W;
    localparam int DIST_W    = SQ_W + 1;

    // per-cell tag that travels with the distance pipeline
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               occ;
        logic [CELL_IW-1:0] idx;
    } meta_t;

endpackage

FILE: rtl/nots_ram.sv
// ----------------------------------------------------------------------------
// nots_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module nots_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end

endmodule

FILE: rtl/nots_dist_unit.sv
// ----------------------------------------------------------------------------
// nots_dist_unit
// Shared distance unit: offsets from the query position to one tile center,
// then the two squared magnitudes, one cell per cycle over two stages.
// ----------------------------------------------------------------------------
module nots_dist_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  nots_pkg::meta_t                      meta_in,
    input  logic [nots_pkg::CENTER_W-1:0]        cx,
    input  logic [nots_pkg::CENTER_W-1:0]        cy,
    input  logic signed [nots_pkg::POS_W-1:0]    px,
    input  logic signed [nots_pkg::POS_W-1:0]    py,
    output nots_pkg::meta_t                      meta_out,
    output logic signed [nots_pkg::OFF_W-1:0]    dx_out,
    output logic signed [nots_pkg::OFF_W-1:0]    dy_out,
    output logic [nots_pkg::SQ_W-1:0]            sqx_out,
    output logic [nots_pkg::SQ_W-1:0]            sqy_out
);
    import nots_pkg::*;

    localparam int CPAD = OFF_W - CENTER_W;

    meta_t                   meta_a_reg;
    logic signed [OFF_W-1:0] dx_a_reg;
    logic signed [OFF_W-1:0] dy_a_reg;
    logic signed [OFF_W-1:0] dx_next;
    logic signed [OFF_W-1:0] dy_next;
    logic [OFF_W-1:0]        ax_full;
    logic [OFF_W-1:0]        ay_full;
    logic [MAG_W-1:0]        ax;
    logic [MAG_W-1:0]        ay;

    // center minus position, exact in 22 bits
    assign dx_next = $signed({{CPAD{1'b0}}, cx}) - $signed({px[POS_W-1], px});
    assign dy_next = $signed({{CPAD{1'b0}}, cy}) - $signed({py[POS_W-1], py});

    // magnitudes stay below 2^21
    assign ax_full = dx_a_reg[OFF_W-1] ? OFF_W'(-dx_a_reg) : OFF_W'(dx_a_reg);
    assign ay_full = dy_a_reg[OFF_W-1] ? OFF_W'(-dy_a_reg) : OFF_W'(dy_a_reg);
    assign ax      = ax_full[MAG_W-1:0];
    assign ay      = ay_full[MAG_W-1:0];

    // stage tags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meta_a_reg <= '0;
            meta_out   <= '0;
        end
        else
        begin
            meta_a_reg <= meta_in;
            meta_out   <= meta_a_reg;
        end
    end

    // offset stage and squaring stage
    always_ff @(posedge clk)
    begin
        dx_a_reg <= dx_next;
        dy_a_reg <= dy_next;
        dx_out   <= dx_a_reg;
        dy_out   <= dy_a_reg;
        sqx_out  <= ax * ax;
        sqy_out  <= ay * ay;
    end

endmodule

FILE: rtl/nots_best_tracker.sv
// ----------------------------------------------------------------------------
// nots_best_tracker
// Adds the squared offsets and keeps the nearest occupied cell seen so far;
// strict compare keeps the lowest index on ties.
// ----------------------------------------------------------------------------
module nots_best_tracker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 start,
    input  nots_pkg::meta_t                      meta,
    input  logic signed [nots_pkg::OFF_W-1:0]    dx,
    input  logic signed [nots_pkg::OFF_W-1:0]    dy,
    input  logic [nots_pkg::SQ_W-1:0]            sqx,
    input  logic [nots_pkg::SQ_W-1:0]            sqy,
    output logic                                 found,
    output logic signed [nots_pkg::OFF_W-1:0]    best_dx,
    output logic signed [nots_pkg::OFF_W-1:0]    best_dy,
    output logic [nots_pkg::CELL_IW-1:0]         best_idx
);
    import nots_pkg::*;

    logic [DIST_W-1:0] dist_sum;
    logic [DIST_W-1:0] best_d_reg;
    logic              take;

    assign dist_sum = {1'b0, sqx} + {1'b0, sqy};
    assign take     = meta.valid && meta.occ && (!found || (dist_sum < best_d_reg));

    // found flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            found <= 1'b0;
        end
        else if (start)
        begin
            found <= 1'b0;
        end
        else if (take)
        begin
            found <= 1'b1;
        end
    end

    // best candidate, zeroed at query start so an empty search reads zero
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            best_d_reg <= '0;
            best_dx    <= '0;
            best_dy    <= '0;
            best_idx   <= '0;
        end
        else if (take)
        begin
            best_d_reg <= dist_sum;
            best_dx    <= dx;
            best_dy    <= dy;
            best_idx   <= meta.idx;
        end
    end

endmodule

FILE: rtl/nearest_occupied_tile_search_unit.sv
// ----------------------------------------------------------------------------
// nearest_occupied_tile_search_unit
// One-bit occupancy map with a sequential nearest occupied tile search.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on the in channel (in_valid/in_stall). A write request
//   (req_type 0) updates one map cell when layer_depth is zero; it gives no
//   result. A query request (req_type 1) scans the cells in use, N =
//   min(world_columns*world_rows, MAX_CELLS) with both counts clamped to
//   1..64, one cell per cycle through the single map read port and the
//   shared distance unit, and delivers one result. in_stall stays high for
//   the whole scan, so queries run one at a time.
//   Results sit in an output register (out_valid/out_stall): the next request
//   is taken while a result waits, and a later query holds its result until
//   the register is free. A stalled result keeps its fields.
//   After reset a clearing pass zeroes the map with in_stall high;
//   configuration writes (cfg_valid/cfg_ready) are always taken and must only
//   be issued while the block is idle.
// ----------------------------------------------------------------------------
module nearest_occupied_tile_search_unit #(
    parameter int MAX_CELLS = 4096
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // request channel
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 req_type,
    input  logic [nots_pkg::CELL_IW-1:0]         cell_index,
    input  logic [nots_pkg::TILE_VW-1:0]         tile_value,
    input  logic [nots_pkg::DEPTH_W-1:0]         layer_depth,
    input  logic signed [nots_pkg::POS_W-1:0]    pos_x,
    input  logic signed [nots_pkg::POS_W-1:0]    pos_y,
    // result channel
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 found,
    output logic signed [nots_pkg::OFF_W-1:0]    offset_x,
    output logic signed [nots_pkg::OFF_W-1:0]    offset_y,
    output logic [nots_pkg::CELL_IW-1:0]         nearest_index,
    // configuration write channel
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [nots_pkg::CFG_IW-1:0]          cfg_index,
    input  logic [nots_pkg::CFG_DW-1:0]          cfg_data
);
    import nots_pkg::*;

    localparam int AW = $clog2(MAX_CELLS);
    localparam int XW = (AW > CELL_IW) ? AW : CELL_IW;
    localparam int USED_W = 2 * COUNT_W;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } state_t;

    state_t state_reg;

    // configuration registers
    logic [COUNT_W-1:0] cols_cfg_reg;
    logic [COUNT_W-1:0] rows_cfg_reg;
    logic [SIZE_W-1:0]  tw_cfg_reg;
    logic [SIZE_W-1:0]  th_cfg_reg;

    // query context
    logic [COUNT_W-2:0]       cols_m1_reg;
    logic [COUNT_W-2:0]       col_reg;
    logic [SIZE_W-1:0]        tw_reg;
    logic [SIZE_W-1:0]        th_reg;
    logic [CELL_IW-1:0]       last_idx_reg;
    logic [CELL_IW-1:0]       scan_i_reg;
    logic                     issue_on_reg;
    logic [CENTER_W-1:0]      cx_reg;
    logic [CENTER_W-1:0]      cy_reg;
    logic signed [POS_W-1:0]  px_reg;
    logic signed [POS_W-1:0]  py_reg;
    logic [AW-1:0]            clr_cnt_reg;

    // read stage aligned with the ram output
    logic                     p1_valid_reg;
    logic                     p1_last_reg;
    logic [CELL_IW-1:0]       p1_idx_reg;
    logic [CENTER_W-1:0]      p1_cx_reg;
    logic [CENTER_W-1:0]      p1_cy_reg;

    logic               in_accept;
    logic               out_free;
    logic               query_start;
    logic [COUNT_W-1:0] cols_c;
    logic [COUNT_W-1:0] rows_c;
    logic [SIZE_W-1:0]  tw_c;
    logic [SIZE_W-1:0]  th_c;
    logic [USED_W-1:0]  used_c;
    logic [USED_W-1:0]  used_m1;
    logic [CELL_IW-1:0] last_idx_c;
    logic [XW-1:0]      wr_idx_ext;
    logic [XW-1:0]      scan_ext;
    logic               wr_in_range;

    logic               ram_we;
    logic [AW-1:0]      ram_addr;
    logic               ram_wdata;
    logic               ram_rdata;

    meta_t                   dist_meta_in;
    meta_t                   trk_meta;
    logic signed [OFF_W-1:0] dist_dx;
    logic signed [OFF_W-1:0] dist_dy;
    logic [SQ_W-1:0]         dist_sqx;
    logic [SQ_W-1:0]         dist_sqy;
    logic                    trk_found;
    logic signed [OFF_W-1:0] trk_dx;
    logic signed [OFF_W-1:0] trk_dy;
    logic [CELL_IW-1:0]      trk_idx;

    function automatic logic [COUNT_W-1:0] clamp_count(input logic [COUNT_W-1:0] v);
        if (v == '0)
        begin
            return COUNT_W'(1);
        end
        if (v > COUNT_W'(64))
        begin
            return COUNT_W'(64);
        end
        return v;
    endfunction

    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
        if (v == '0)
        begin
            return SIZE_W'(1);
        end
        if (v > SIZE_W'(256))
        begin
            return SIZE_W'(256);
        end
        return v;
    endfunction

    // handshakes
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign query_start = in_accept && req_type;
    assign out_free    = !out_valid || !out_stall;
    assign cfg_ready   = 1'b1;

    // clamped configuration seen at query start
    assign cols_c     = clamp_count(cols_cfg_reg);
    assign rows_c     = clamp_count(rows_cfg_reg);
    assign tw_c       = clamp_size(tw_cfg_reg);
    assign th_c       = clamp_size(th_cfg_reg);
    assign used_c     = cols_c * rows_c;
    assign used_m1    = used_c - USED_W'(1);
    assign last_idx_c = (int'(used_c) > MAX_CELLS) ? CELL_IW'(MAX_CELLS - 1)
                                                   : used_m1[CELL_IW-1:0];

    // map port selection
    assign wr_idx_ext  = XW'(cell_index);
    assign scan_ext    = XW'(scan_i_reg);
    assign wr_in_range = ({1'b0, wr_idx_ext} < (XW + 1)'(MAX_CELLS));

    always_comb
    begin
        ram_we    = 1'b0;
        ram_wdata = 1'b0;
        ram_addr  = wr_idx_ext[AW-1:0];
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we   = 1'b1;
                ram_addr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                ram_we    = in_accept && !req_type && (layer_depth == '0) && wr_in_range;
                ram_wdata = (tile_value != '0);
            end
            ST_SCAN:
            begin
                ram_addr = scan_ext[AW-1:0];
            end
            default:
            begin
                ram_addr = scan_ext[AW-1:0];
            end
        endcase
    end

    nots_ram #(
        .WIDTH (1),
        .DEPTH (MAX_CELLS)
    ) u_map (
        .clk   (clk),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (ram_wdata),
        .rdata (ram_rdata)
    );

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_cfg_reg <= COUNT_W'(64);
            rows_cfg_reg <= COUNT_W'(64);
            tw_cfg_reg   <= SIZE_W'(16);
            th_cfg_reg   <= SIZE_W'(16);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_WORLD_COLUMNS: cols_cfg_reg <= cfg_data[COUNT_W-1:0];
                REG_WORLD_ROWS:    rows_cfg_reg <= cfg_data[COUNT_W-1:0];
                REG_TILE_WIDTH:    tw_cfg_reg   <= cfg_data[SIZE_W-1:0];
                REG_TILE_HEIGHT:   th_cfg_reg   <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    // sequencer: clearing pass, scan issue and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_CLEAR;
            clr_cnt_reg  <= '0;
            issue_on_reg <= 1'b0;
            p1_valid_reg <= 1'b0;
            out_valid    <= 1'b0;
        end
        else
        begin
            p1_valid_reg <= (state_reg == ST_SCAN) && issue_on_reg;
            if (out_valid && !out_stall && (state_reg != ST_FINISH))
            begin
                out_valid <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + AW'(1);
                    if (clr_cnt_reg == AW'(MAX_CELLS - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (query_start)
                    begin
                        state_reg    <= ST_SCAN;
                        issue_on_reg <= 1'b1;
                    end
                end
                ST_SCAN:
                begin
                    if (issue_on_reg)
                    begin
                        if (scan_i_reg == last_idx_reg)
                        begin
                            issue_on_reg <= 1'b0;
                        end
                    end
                    if (trk_meta.valid && trk_meta.last)
                    begin
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (out_free)
                    begin
                        out_valid <= 1'b1;
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // scan counters and center stepping, no reset needed
    always_ff @(posedge clk)
    begin
        if (query_start)
        begin
            cols_m1_reg  <= cols_c[COUNT_W-2:0] - (COUNT_W - 1)'(1);
            tw_reg       <= tw_c;
            th_reg       <= th_c;
            last_idx_reg <= last_idx_c;
            px_reg       <= pos_x;
            py_reg       <= pos_y;
            scan_i_reg   <= '0;
            col_reg      <= '0;
            cx_reg       <= CENTER_W'({tw_c, 3'b000});
            cy_reg       <= CENTER_W'({th_c, 3'b000});
        end
        else if ((state_reg == ST_SCAN) && issue_on_reg)
        begin
            p1_last_reg <= (scan_i_reg == last_idx_reg);
            p1_idx_reg  <= scan_i_reg;
            p1_cx_reg   <= cx_reg;
            p1_cy_reg   <= cy_reg;
            scan_i_reg  <= scan_i_reg + CELL_IW'(1);
            if (col_reg == cols_m1_reg)
            begin
                col_reg <= '0;
                cx_reg  <= CENTER_W'({tw_reg, 3'b000});
                cy_reg  <= cy_reg + CENTER_W'({th_reg, 4'b0000});
            end
            else
            begin
                col_reg <= col_reg + (COUNT_W - 1)'(1);
                cx_reg  <= cx_reg + CENTER_W'({tw_reg, 4'b0000});
            end
        end
    end

    // result fields
    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_FINISH) && out_free)
        begin
            found         <= trk_found;
            offset_x      <= trk_dx;
            offset_y      <= trk_dy;
            nearest_index <= trk_idx;
        end
    end

    // distance pipeline
    assign dist_meta_in.valid = p1_valid_reg;
    assign dist_meta_in.last  = p1_last_reg;
    assign dist_meta_in.occ   = ram_rdata;
    assign dist_meta_in.idx   = p1_idx_reg;

    nots_dist_unit u_dist (
        .clk      (clk),
        .rst_n    (rst_n),
        .meta_in  (dist_meta_in),
        .cx       (p1_cx_reg),
        .cy       (p1_cy_reg),
        .px       (px_reg),
        .py       (py_reg),
        .meta_out (trk_meta),
        .dx_out   (dist_dx),
        .dy_out   (dist_dy),
        .sqx_out  (dist_sqx),
        .sqy_out  (dist_sqy)
    );

    nots_best_tracker u_best (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (query_start),
        .meta     (trk_meta),
        .dx       (dist_dx),
        .dy       (dist_dy),
        .sqx      (dist_sqx),
        .sqy      (dist_sqy),
        .found    (trk_found),
        .best_dx  (trk_dx),
        .best_dy  (trk_dy),
        .best_idx (trk_idx)
    );

    // checks
    a_pipe_only_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        trk_meta.valid |-> (state_reg == ST_SCAN))
        else $error("distance pipeline active outside a scan");

    a_best_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (trk_found && ((state_reg == ST_SCAN) || (state_reg == ST_FINISH)))
        |-> (trk_idx <= last_idx_reg))
        else $error("nearest index beyond the cells in use");

    a_result_from_finish: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_FINISH))
        else $error("result raised without a finished scan");

endmodule
